FILE: rtl/krt_pkg.sv
// ----------------------------------------------------------------------------
// Key remap table package
// Action and status codes, controller states and fixed widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package krt_pkg;

    localparam int unsigned KEY_W    = 32;
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_CLEAR  = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic {
        CFG_REMAP_ENABLE = 1'b0,
        CFG_NO_KEY_CODE  = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

FILE: rtl/key_remap_table_top.sv
// ----------------------------------------------------------------------------
// Key remap table
// Holds up to ENTRIES source/target key pairs in one synchronous memory.
// A lookup walks the stored pairs one entry per cycle through the single
// memory read port and returns the target of the first match. The scan
// ends at the first hit or after the last stored entry, and the result
// goes through the result registers into the output register. A lookup
// that bypasses the table (remap disabled, no-key code or empty table), an
// add, a clear and the unused action code set the result registers straight
// from the transfer in. The input is ready again once the result is
// loaded into the output register, and a full table holds ENTRIES pairs,
// 255 by default. One item is worked on at a time; a finished result
// waits in the output register while the next item is taken in, and a result
// that is still waiting there holds the next one back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_remap_table_top
    import krt_pkg::*;
#(
    parameter int unsigned ENTRIES = 255
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [KEY_W-1:0]    i_cfg_data,

    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [KEY_W-1:0]    i_key_in,
    input  logic [KEY_W-1:0]    i_key_target,

    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [KEY_W-1:0]    o_key_result,
    output logic                o_hit,
    output logic [STATUS_W-1:0] o_status
);

    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    // Table memory: {source, target}
    logic [2*KEY_W-1:0] r_mem [ENTRIES];
    logic [2*KEY_W-1:0] r_rd_data;

    t_state             r_state, n_state;
    logic               r_remap_enable;
    logic [KEY_W-1:0]   r_no_key_code;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_addr, n_addr;
    logic               r_issue, n_issue;
    logic               r_cmp_valid, n_cmp_valid;
    logic               r_cmp_last, n_cmp_last;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [KEY_W-1:0]   r_res_key, n_res_key;
    logic               r_res_hit, n_res_hit;
    t_status            r_res_status, n_res_status;
    logic               r_out_valid, n_out_valid;
    logic [KEY_W-1:0]   r_out_key, n_out_key;
    logic               r_out_hit, n_out_hit;
    t_status            r_out_status, n_out_status;

    logic               in_fire;
    logic               out_fire;
    logic               wr_en;
    logic               addr_last;
    logic [KEY_W-1:0]   rd_source;
    logic [KEY_W-1:0]   rd_target;

    assign o_in_ready   = (r_state == S_IDLE);
    assign in_fire      = i_in_valid && o_in_ready;
    assign out_fire     = r_out_valid && i_out_ready;
    assign o_out_valid  = r_out_valid;
    assign o_key_result = r_out_key;
    assign o_hit        = r_out_hit;
    assign o_status     = r_out_status;

    assign addr_last = ((CW'(r_addr) + CW'(1)) == r_count);
    assign rd_source = r_rd_data[2*KEY_W-1:KEY_W];
    assign rd_target = r_rd_data[KEY_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_addr       = r_addr;
        n_issue      = r_issue;
        n_cmp_valid  = 1'b0;
        n_cmp_last   = r_cmp_last;
        n_key        = r_key;
        n_res_key    = r_res_key;
        n_res_hit    = r_res_hit;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !out_fire;
        n_out_key    = r_out_key;
        n_out_hit    = r_out_hit;
        n_out_status = r_out_status;
        wr_en        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_key        = i_key_in;
                    n_res_key    = '0;
                    n_res_hit    = 1'b0;
                    n_res_status = ST_OK;
                    n_state      = S_DONE;
                    case (i_action)
                        ACT_LOOKUP: begin
                            if (r_remap_enable && (i_key_in != r_no_key_code)
                                    && (r_count != '0)) begin
                                n_state = S_SCAN;
                                n_addr  = '0;
                                n_issue = 1'b1;
                            end else begin
                                n_res_key = i_key_in;
                            end
                        end
                        ACT_ADD: begin
                            if ((i_key_in == r_no_key_code)
                                    || (i_key_target == r_no_key_code)) begin
                                n_res_status = ST_INVALID;
                            end else if (r_count == CW'(ENTRIES)) begin
                                n_res_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        ACT_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_issue) begin
                    n_cmp_valid = 1'b1;
                    n_cmp_last  = addr_last;
                    if (addr_last) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end
                if (r_cmp_valid) begin
                    if (rd_source == r_key) begin
                        n_res_key   = rd_target;
                        n_res_hit   = 1'b1;
                        n_state     = S_DONE;
                        n_cmp_valid = 1'b0;
                        n_issue     = 1'b0;
                    end else if (r_cmp_last) begin
                        n_res_key   = r_key;
                        n_state     = S_DONE;
                        n_cmp_valid = 1'b0;
                        n_issue     = 1'b0;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_key    = r_res_key;
                    n_out_hit    = r_res_hit;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_issue        <= 1'b0;
            r_cmp_valid    <= 1'b0;
            r_out_valid    <= 1'b0;
            r_remap_enable <= 1'b0;
            r_no_key_code  <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_REMAP_ENABLE: r_remap_enable <= i_cfg_data[0];
                    CFG_NO_KEY_CODE:  r_no_key_code  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_cmp_last   <= n_cmp_last;
        r_key        <= n_key;
        r_res_key    <= n_res_key;
        r_res_hit    <= n_res_hit;
        r_res_status <= n_res_status;
        r_out_key    <= n_out_key;
        r_out_hit    <= n_out_hit;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[AW-1:0]] <= {i_key_in, i_key_target};
        end
        r_rd_data <= r_mem[r_addr];
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("entry count beyond table size");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_action == ACT_CLEAR)) |=> (r_count == '0))
        else $error("clear did not empty the table");

    a_cmp_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_valid |-> (r_state == S_SCAN))
        else $error("compare stage active outside scan");

    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> (o_status == ST_OK))
        else $error("hit reported with nonzero status");
`endif

endmodule
